@@ design/sync_framed_sum8_deframer_assert.svh @@
// Assertion macros for the sum8 deframer checker.
`ifndef SYNC_FRAMED_SUM8_DEFRAMER_ASSERT_SVH
`define SYNC_FRAMED_SUM8_DEFRAMER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SFS8_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// Implication checked in the cycle after the condition.
`define SFS8_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ design/sfs8_pkg.sv @@
// Shared constants and types of the sum8 deframer.
package sfs8_pkg;

    localparam int FRAME_BYTES_DEF = 16;
    localparam int Q_DEPTH         = 4;

    localparam logic [7:0]  HDR_FIRST  = 8'h42;
    localparam logic [7:0]  HDR_SECOND = 8'h03;
    localparam logic [31:0] POS_MAX    = 32'hFFFF_FFFF;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_NO_HEADER  = 2'd1;
    localparam logic [1:0] ERR_CHECKSUM   = 2'd2;
    localparam logic [1:0] ERR_UNFINISHED = 2'd3;

    localparam int M_DATA_W = 64;

    // one job for the back end: an error report or a buffered frame
    typedef struct packed {
        logic        is_err;
        logic [1:0]  code;
        logic [31:0] pos;
        logic [7:0]  exp_sum;
        logic [7:0]  act_sum;
        logic        slot;
    } cmd_t;

    // frame buffer slot handed back to the front end
    typedef struct packed {
        logic vld;
        logic slot;
    } rel_t;

endpackage

@@ design/sfs8_queue.sv @@
// Short command queue between the front and back ends.
module sfs8_queue
    import sfs8_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             q_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ design/sfs8_front.sv @@
// Front end: header hunt, frame collection, checksum and end-of-stream checks.
module sfs8_front
    import sfs8_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,
    input  logic                              s_tuser,
    input  logic                              q_full,
    output logic                              push,
    output cmd_t                              push_cmd,
    output logic                              wr_en,
    output logic [$clog2(2*FRAME_BYTES)-1:0]  wr_addr,
    output logic [7:0]                        wr_data,
    input  rel_t                              rel
);

    localparam int FILL_W = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W  = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int ADDR_W = $clog2(2 * FRAME_BYTES);

    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_GOT42  = 2'd1;
    localparam logic [1:0] PH_FRAMES = 2'd2;

    logic [1:0]        phase_reg, phase_next;
    logic [31:0]       index_reg, index_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        sum_reg, sum_next;
    logic              wr_slot_reg, wr_slot_next;
    logic [1:0]        busy_reg, busy_next;

    logic        accept;
    logic [31:0] index_inc;
    logic [IDX_W-1:0] fill_idx;

    // hold off while the queue is full or the next frame would land in a slot the back end still reads
    assign s_tready = !q_full &&
                      !((phase_reg == PH_FRAMES) && (fill_reg == '0) && busy_reg[wr_slot_reg]);
    assign accept    = s_tvalid && s_tready;
    assign index_inc = (index_reg == POS_MAX) ? POS_MAX : index_reg + 32'd1;
    assign fill_idx  = fill_reg[IDX_W-1:0];

    assign wr_data = s_tdata;
    assign wr_addr = wr_slot_reg ? ADDR_W'(FRAME_BYTES) + ADDR_W'(fill_idx) : ADDR_W'(fill_idx);

    always_comb begin
        phase_next   = phase_reg;
        index_next   = index_reg;
        fill_next    = fill_reg;
        sum_next     = sum_reg;
        wr_slot_next = wr_slot_reg;
        busy_next    = busy_reg;
        push         = 1'b0;
        push_cmd     = '0;
        wr_en        = 1'b0;

        if (rel.vld) begin
            busy_next[rel.slot] = 1'b0;
        end

        if (accept) begin
            if (s_tuser) begin
                // end of stream
                if (phase_reg != PH_FRAMES) begin
                    if (index_reg != '0) begin
                        push            = 1'b1;
                        push_cmd.is_err = 1'b1;
                        push_cmd.code   = ERR_NO_HEADER;
                        push_cmd.pos    = index_reg;
                    end
                end else if (fill_reg != '0) begin
                    push            = 1'b1;
                    push_cmd.is_err = 1'b1;
                    push_cmd.code   = ERR_UNFINISHED;
                    push_cmd.pos    = (index_reg == POS_MAX) ? POS_MAX
                                                             : index_reg - 32'(fill_reg);
                end
                phase_next = PH_HUNT;
                index_next = '0;
                fill_next  = '0;
                sum_next   = '0;
            end else begin
                index_next = index_inc;
                case (phase_reg)
                    PH_HUNT: begin
                        if (s_tdata == HDR_FIRST) begin
                            phase_next = PH_GOT42;
                        end
                    end
                    PH_GOT42: begin
                        if (s_tdata == HDR_SECOND) begin
                            phase_next = PH_FRAMES;
                            fill_next  = '0;
                            sum_next   = '0;
                        end else if (s_tdata != HDR_FIRST) begin
                            phase_next = PH_HUNT;
                        end
                    end
                    PH_FRAMES: begin
                        if (fill_reg < FILL_W'(FRAME_BYTES)) begin
                            wr_en     = 1'b1;
                            fill_next = fill_reg + 1'b1;
                            sum_next  = sum_reg + s_tdata;
                        end else begin
                            push = 1'b1;
                            if (s_tdata == sum_reg) begin
                                push_cmd.slot          = wr_slot_reg;
                                busy_next[wr_slot_reg] = 1'b1;
                                wr_slot_next           = !wr_slot_reg;
                            end else begin
                                push_cmd.is_err  = 1'b1;
                                push_cmd.code    = ERR_CHECKSUM;
                                push_cmd.pos     = index_inc;
                                push_cmd.exp_sum = s_tdata;
                                push_cmd.act_sum = sum_reg;
                            end
                            fill_next = '0;
                            sum_next  = '0;
                        end
                    end
                    default: begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            index_reg   <= '0;
            fill_reg    <= '0;
            sum_reg     <= '0;
            wr_slot_reg <= 1'b0;
            busy_reg    <= '0;
        end else begin
            phase_reg   <= phase_next;
            index_reg   <= index_next;
            fill_reg    <= fill_next;
            sum_reg     <= sum_next;
            wr_slot_reg <= wr_slot_next;
            busy_reg    <= busy_next;
        end
    end

endmodule

@@ design/sfs8_back.sv @@
// Back end: frame buffer, readout sequencer and output register.
module sfs8_back
    import sfs8_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_empty,
    input  cmd_t                              q_head,
    output logic                              q_pop,
    input  logic                              wr_en,
    input  logic [$clog2(2*FRAME_BYTES)-1:0]  wr_addr,
    input  logic [7:0]                        wr_data,
    output rel_t                              rel,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [M_DATA_W-1:0]               m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);

    localparam int IDX_W  = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int ADDR_W = $clog2(2 * FRAME_BYTES);
    localparam int PAD_W  = M_DATA_W - 58;

    logic [7:0] frame_mem [2*FRAME_BYTES];

    logic             active_reg, active_next;
    logic             slot_reg, slot_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // read stage: registered memory data plus error fields
    logic        rd_vld_reg, rd_vld_next;
    logic        rd_err_reg;
    logic [7:0]  rd_byte_reg;
    logic [1:0]  rd_code_reg;
    logic [31:0] rd_pos_reg;
    logic [7:0]  rd_exp_reg;
    logic [7:0]  rd_act_reg;
    logic        rd_last_reg;

    // output register
    logic        m_vld_reg, m_vld_next;
    logic        m_err_reg;
    logic [7:0]  m_byte_reg;
    logic [1:0]  m_code_reg;
    logic [31:0] m_pos_reg;
    logic [7:0]  m_exp_reg;
    logic [7:0]  m_act_reg;
    logic        m_last_reg;

    logic              load_out, slot_free, start_frame, issue_err, issue_rd, at_last;
    logic [ADDR_W-1:0] rd_addr;

    assign load_out    = rd_vld_reg && (!m_vld_reg || m_tready);
    assign slot_free   = !rd_vld_reg || load_out;
    assign start_frame = !active_reg && !q_empty && !q_head.is_err;
    assign issue_err   = !active_reg && !q_empty && q_head.is_err && slot_free;
    assign issue_rd    = active_reg && slot_free;
    assign at_last     = (idx_reg == IDX_W'(FRAME_BYTES - 1));
    assign q_pop       = start_frame || issue_err;
    assign rd_addr     = slot_reg ? ADDR_W'(FRAME_BYTES) + ADDR_W'(idx_reg) : ADDR_W'(idx_reg);

    // slot is free for the front end once its last byte is in the read stage
    assign rel.vld  = issue_rd && at_last;
    assign rel.slot = slot_reg;

    always_comb begin
        active_next = active_reg;
        slot_next   = slot_reg;
        idx_next    = idx_reg;
        if (start_frame) begin
            active_next = 1'b1;
            slot_next   = q_head.slot;
            idx_next    = '0;
        end else if (issue_rd) begin
            idx_next = idx_reg + 1'b1;
            if (at_last) begin
                active_next = 1'b0;
            end
        end

        rd_vld_next = rd_vld_reg;
        if (issue_rd || issue_err) begin
            rd_vld_next = 1'b1;
        end else if (load_out) begin
            rd_vld_next = 1'b0;
        end

        m_vld_next = m_vld_reg;
        if (load_out) begin
            m_vld_next = 1'b1;
        end else if (m_tready) begin
            m_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            slot_reg   <= 1'b0;
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
        end else begin
            active_reg <= active_next;
            slot_reg   <= slot_next;
            idx_reg    <= idx_next;
            rd_vld_reg <= rd_vld_next;
            m_vld_reg  <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            frame_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue_rd) begin
            rd_err_reg  <= 1'b0;
            rd_byte_reg <= frame_mem[rd_addr];
            rd_code_reg <= ERR_NONE;
            rd_pos_reg  <= '0;
            rd_exp_reg  <= '0;
            rd_act_reg  <= '0;
            rd_last_reg <= at_last;
        end else if (issue_err) begin
            rd_err_reg  <= 1'b1;
            rd_byte_reg <= '0;
            rd_code_reg <= q_head.code;
            rd_pos_reg  <= q_head.pos;
            rd_exp_reg  <= q_head.exp_sum;
            rd_act_reg  <= q_head.act_sum;
            rd_last_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_err_reg  <= rd_err_reg;
            m_byte_reg <= rd_byte_reg;
            m_code_reg <= rd_code_reg;
            m_pos_reg  <= rd_pos_reg;
            m_exp_reg  <= rd_exp_reg;
            m_act_reg  <= rd_act_reg;
            m_last_reg <= rd_last_reg;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tuser  = m_err_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_act_reg, m_exp_reg, m_pos_reg, m_code_reg, m_byte_reg};

endmodule

@@ design/sync_framed_sum8_deframer.sv @@
// Top level of the sync-word deframer with sum8 frame checksum.
//
//  channel | dir | tdata fields (low bit first)                  | tuser        | tlast
//  --------+-----+-----------------------------------------------+--------------+------------
//  s_      | in  | data_byte[7:0]                                | kind         | -
//  m_      | out | msg_byte[7:0] error_code[9:8]                 | result_kind  | last_of_run
//          |     | error_position[41:10] expected_sum[49:42]     |              |
//          |     | actual_sum[57:50], zero pad to 64             |              |
//
// Cycles: the front end takes one word per cycle while s_tready is high. The back end
// emits one word per cycle while m_tready allows; a good frame takes a start step and
// then one readout per byte, through the single read port of the frame buffer.
// Stalls: s_tready drops while the 4-entry command queue is full or while both
// frame buffer slots still wait for readout; m_tready low backs up the read stage.
// Reset: synchronous; the frame buffer needs no clearing pass.
module sync_framed_sum8_deframer
    import sfs8_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // data_byte
    input  logic                s_tuser,   // kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // msg_byte, error_code, error_position,
                                           // expected_sum, actual_sum
    output logic                m_tuser,   // result_kind
    output logic                m_tlast    // last_of_run
);

    localparam int ADDR_W = $clog2(2 * FRAME_BYTES);

    logic              push, pop, q_full, q_empty;
    cmd_t              push_cmd, q_head;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    rel_t              rel;

    // header hunt, collection and checks; one word per cycle while s_tready is high
    sfs8_front #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rel      (rel)
    );

    // decouples the two ends: error reports and frame-ready jobs in order
    sfs8_queue #(
        .DEPTH(Q_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // two-slot frame buffer and output sequencing
    sfs8_back #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (pop),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rel      (rel),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ design/sfs8_checker.sv @@
// Port-level checker for the sum8 deframer and its bind.
`include "sync_framed_sum8_deframer_assert.svh"

module sfs8_checker
    import sfs8_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser,
    input logic                m_tlast
);

    `SFS8_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped under stall")
    `SFS8_ASSERT_IMP(a_err_last, m_tvalid && m_tuser, m_tlast && (m_tdata[9:8] != ERR_NONE), "error word not last or has no code")
    `SFS8_ASSERT_IMP(a_msg_clean, m_tvalid && !m_tuser, m_tdata[57:8] == '0, "message word carries error fields")
    `SFS8_ASSERT_IMP(a_err_nobyte, m_tvalid && m_tuser, m_tdata[7:0] == 8'd0, "error word carries a message byte")

endmodule

bind sync_framed_sum8_deframer sfs8_checker u_sfs8_checker (.*);
